FILE: rtl/core/bmeic_pkg.sv
// ---------------------------------------------------------------------------
// Bank mapper package
// Shared operation codes, register decode addresses and constants for the
// cartridge bank mapper with its A12 edge IRQ counter.
// ---------------------------------------------------------------------------
package bmeic_pkg;

    // Field widths of one request and one result.
    localparam int OP_W     = 3;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int MAP_W    = 19;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // Operation codes carried on the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_REG_WRITE = 3'd0,
        OP_PRG_MAP   = 3'd1,
        OP_CHR_MAP   = 3'd2,
        OP_NT_MAP    = 3'd3,
        OP_RAM_READ  = 3'd4,
        OP_RAM_WRITE = 3'd5,
        OP_TICK      = 3'd6
    } t_op;

    // Register decode: CPU address masked with REG_DECODE_MASK.
    localparam logic [ADDR_W-1:0] REG_DECODE_MASK = 16'he001;
    localparam logic [ADDR_W-1:0] REG_BANK_SELECT = 16'h8000;
    localparam logic [ADDR_W-1:0] REG_BANK_DATA   = 16'h8001;
    localparam logic [ADDR_W-1:0] REG_MIRRORING   = 16'ha000;
    localparam logic [ADDR_W-1:0] REG_RAM_PROTECT = 16'ha001;
    localparam logic [ADDR_W-1:0] REG_IRQ_LATCH   = 16'hc000;
    localparam logic [ADDR_W-1:0] REG_IRQ_RELOAD  = 16'hc001;
    localparam logic [ADDR_W-1:0] REG_IRQ_DISABLE = 16'he000;
    localparam logic [ADDR_W-1:0] REG_IRQ_ENABLE  = 16'he001;

    // Fixed PRG banks and the A12 edge hold-off length.
    localparam logic [5:0] PRG_BANK_SECOND_LAST = 6'h3e;
    localparam logic [5:0] PRG_BANK_LAST        = 6'h3f;
    localparam logic [2:0] HOLDOFF_CYCLES       = 3'd6;

endpackage

FILE: rtl/core/bank_mapper_with_edge_irq_counter_top.sv
// ---------------------------------------------------------------------------
// Bank mapper with edge IRQ counter
// Translates CPU and PPU addresses through switchable banks, decodes mapper
// register writes and counts PPU A12 transitions of one polarity to raise a scanline interrupt.
// ---------------------------------------------------------------------------
// Usage:
// Requests enter on the s_axis channel: tuser holds the operation code and
// tdata holds the address (bits 15..0) and the register data (bits 23..16).
// Every request produces exactly one result on the m_axis channel: the
// mapped address, the PRG-RAM access permission and the IRQ level after the
// request has been applied.
// The cfg channel writes the edge polarity bit; it is always ready and should
// only be written while no request is in flight.
// A request passes an input register and a result register: it is held in the
// input register once accepted and is presented on m_axis from the result
// register. One request is taken every cycle while the receiver takes the
// results; the throughput is set by the combinational decode and counter
// update between the two registers.
// When the receiver stalls, the result register holds and the input register
// still accepts one more request; after that s_axis_tready drops until the
// result is taken.
// Reset clears both stages and loads the mapper state with its power-on
// values (PRG-RAM enabled, all banks zero, IRQ off, rising edges counted).
// ---------------------------------------------------------------------------
module bank_mapper_with_edge_irq_counter_top
    import bmeic_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Request channel.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: address [15:0], data [23:16]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: operation [2:0]
    input  logic [OP_W-1:0]        s_axis_tuser,
    // Result channel.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: mapped_address [18:0], access_allowed [19], irq_line [20],
    // zero fill [23:21]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // Configuration channel: falling_edge_irq.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_data
);

    // Input stage.
    logic              r_in_valid;
    t_op               r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_data;

    // Result stage.
    logic              r_out_valid;
    logic [MAP_W-1:0]  r_mapped;
    logic              r_allowed;
    logic              r_irq_line;

    // Configuration.
    logic              r_falling_edge;

    // Mapper state.
    logic              r_chr_mode,       n_chr_mode;
    logic              r_prg_mode,       n_prg_mode;
    logic [2:0]        r_bank_select,    n_bank_select;
    logic [5:0]        r_prg_banks [2];
    logic [5:0]        n_prg_banks [2];
    logic [7:0]        r_chr_banks [6];
    logic [7:0]        n_chr_banks [6];
    logic              r_mirror,         n_mirror;
    logic              r_ram_enable,     n_ram_enable;
    logic              r_ram_protect,    n_ram_protect;
    logic [7:0]        r_irq_reload,     n_irq_reload;
    logic [7:0]        r_irq_count,      n_irq_count;
    logic              r_irq_enabled,    n_irq_enabled;
    logic [2:0]        r_holdoff,        n_holdoff;
    logic              r_irq_pending,    n_irq_pending;
    logic              r_last_a12,       n_last_a12;

    // Result of the request in the input stage.
    logic [MAP_W-1:0]  n_mapped;
    logic              n_allowed;

    // Helpers for the translations and the edge detector.
    logic              advance;
    logic [5:0]        prg_bank;
    logic [2:0]        chr_slot;
    logic [2:0]        chr_index;
    logic [7:0]        chr_bank;
    logic              a12;
    logic              a12_edge;
    logic [2:0]        holdoff_dec;

    // The input stage moves on when the result register is free or emptying.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_irq_line, r_allowed, r_mapped};

    // PRG window select from address bits 14..13.
    always_comb begin
        case (r_addr[14:13])
            2'd0:    prg_bank = r_prg_mode ? PRG_BANK_SECOND_LAST : r_prg_banks[0];
            2'd1:    prg_bank = r_prg_banks[1];
            2'd2:    prg_bank = r_prg_mode ? r_prg_banks[0] : PRG_BANK_SECOND_LAST;
            default: prg_bank = PRG_BANK_LAST;
        endcase
    end

    // CHR slot select; the mode bit swaps the two 4K halves.
    always_comb begin
        chr_slot = r_addr[12:10] ^ {r_chr_mode, 2'b00};
        if (!chr_slot[2]) begin
            chr_index = {2'b00, chr_slot[1]};
        end else begin
            chr_index = chr_slot - 3'd2;
        end
        chr_bank = r_chr_banks[chr_index];
    end

    // A12 edge detection with the hold-off counted down first.
    assign a12         = r_addr[12];
    assign a12_edge    = r_falling_edge ? (r_last_a12 && !a12) : (!r_last_a12 && a12);
    assign holdoff_dec = (r_holdoff != 3'd0) ? (r_holdoff - 3'd1) : 3'd0;

    // Next state and result for the request in the input stage.
    always_comb begin
        n_chr_mode    = r_chr_mode;
        n_prg_mode    = r_prg_mode;
        n_bank_select = r_bank_select;
        n_prg_banks   = r_prg_banks;
        n_chr_banks   = r_chr_banks;
        n_mirror      = r_mirror;
        n_ram_enable  = r_ram_enable;
        n_ram_protect = r_ram_protect;
        n_irq_reload  = r_irq_reload;
        n_irq_count   = r_irq_count;
        n_irq_enabled = r_irq_enabled;
        n_holdoff     = r_holdoff;
        n_irq_pending = r_irq_pending;
        n_last_a12    = r_last_a12;
        n_mapped      = '0;
        n_allowed     = 1'b0;

        case (r_op)
            OP_REG_WRITE: begin
                case (r_addr & REG_DECODE_MASK)
                    REG_BANK_SELECT: begin
                        n_chr_mode    = r_data[7];
                        n_prg_mode    = r_data[6];
                        n_bank_select = r_data[2:0];
                    end
                    REG_BANK_DATA: begin
                        if (r_bank_select < 3'd2) begin
                            n_chr_banks[r_bank_select] = {r_data[7:1], 1'b0};
                        end else if (r_bank_select < 3'd6) begin
                            n_chr_banks[r_bank_select] = r_data;
                        end else begin
                            n_prg_banks[r_bank_select[0]] = r_data[5:0];
                        end
                    end
                    REG_MIRRORING: begin
                        n_mirror = r_data[0];
                    end
                    REG_RAM_PROTECT: begin
                        n_ram_enable  = r_data[7];
                        n_ram_protect = r_data[6];
                    end
                    REG_IRQ_LATCH: begin
                        n_irq_reload = r_data;
                    end
                    REG_IRQ_RELOAD: begin
                        n_irq_count = 8'd0;
                    end
                    REG_IRQ_DISABLE: begin
                        n_irq_enabled = 1'b0;
                        n_irq_pending = 1'b0;
                    end
                    REG_IRQ_ENABLE: begin
                        n_irq_enabled = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            OP_PRG_MAP: begin
                n_mapped = {prg_bank, r_addr[12:0]};
            end
            OP_CHR_MAP: begin
                if (!chr_slot[2]) begin
                    n_mapped = {1'b0, chr_bank, 10'd0} | {8'd0, r_addr[10:0]};
                end else begin
                    n_mapped = {1'b0, chr_bank, r_addr[9:0]};
                end
            end
            OP_NT_MAP: begin
                n_mapped = {8'd0, (r_mirror ? r_addr[11] : r_addr[10]), r_addr[9:0]};
            end
            OP_RAM_READ: begin
                n_mapped  = {6'd0, r_addr[12:0]};
                n_allowed = r_ram_enable;
            end
            OP_RAM_WRITE: begin
                n_mapped  = {6'd0, r_addr[12:0]};
                n_allowed = r_ram_enable && !r_ram_protect;
            end
            OP_TICK: begin
                n_holdoff  = holdoff_dec;
                n_last_a12 = a12;
                if (a12_edge) begin
                    // A counted edge reloads from zero or counts down.
                    if (holdoff_dec == 3'd0) begin
                        if (r_irq_count == 8'd0) begin
                            n_irq_count = r_irq_reload;
                        end else begin
                            n_irq_count = r_irq_count - 8'd1;
                            if (r_irq_count == 8'd1 && r_irq_enabled) begin
                                n_irq_pending = 1'b1;
                            end
                        end
                    end
                    n_holdoff = HOLDOFF_CYCLES;
                end
            end
            default: begin
            end
        endcase
    end

    // Handshake control of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input and result payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op   <= t_op'(s_axis_tuser);
            r_addr <= s_axis_tdata[ADDR_W-1:0];
            r_data <= s_axis_tdata[ADDR_W +: DATA_W];
        end
        if (advance) begin
            r_mapped   <= n_mapped;
            r_allowed  <= n_allowed;
            r_irq_line <= n_irq_pending;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_falling_edge <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_falling_edge <= i_cfg_data;
        end
    end

    // Mapper state updates once per request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chr_mode    <= 1'b0;
            r_prg_mode    <= 1'b0;
            r_bank_select <= 3'd0;
            r_prg_banks   <= '{default: '0};
            r_chr_banks   <= '{default: '0};
            r_mirror      <= 1'b0;
            r_ram_enable  <= 1'b1;
            r_ram_protect <= 1'b0;
            r_irq_reload  <= 8'd0;
            r_irq_count   <= 8'd0;
            r_irq_enabled <= 1'b0;
            r_holdoff     <= 3'd0;
            r_irq_pending <= 1'b0;
            r_last_a12    <= 1'b0;
        end else if (advance) begin
            r_chr_mode    <= n_chr_mode;
            r_prg_mode    <= n_prg_mode;
            r_bank_select <= n_bank_select;
            r_prg_banks   <= n_prg_banks;
            r_chr_banks   <= n_chr_banks;
            r_mirror      <= n_mirror;
            r_ram_enable  <= n_ram_enable;
            r_ram_protect <= n_ram_protect;
            r_irq_reload  <= n_irq_reload;
            r_irq_count   <= n_irq_count;
            r_irq_enabled <= n_irq_enabled;
            r_holdoff     <= n_holdoff;
            r_irq_pending <= n_irq_pending;
            r_last_a12    <= n_last_a12;
        end
    end

endmodule
